// ----- rtl/iafhu_pkg.sv -----
// ----------------------------------------------------------------------------
// iafhu_pkg
// Shared types and constants of the IMU angle frame heading unwrap block.
// ----------------------------------------------------------------------------
package iafhu_pkg;

   // frame layout
   localparam int FRAME_BYTES  = 11;
   localparam int POS_BITS     = 4;
   localparam logic [POS_BITS-1:0] TYPE_POS   = POS_BITS'(1);
   localparam logic [POS_BITS-1:0] YAW_LO_POS = POS_BITS'(6);
   localparam logic [POS_BITS-1:0] YAW_HI_POS = POS_BITS'(7);
   localparam logic [POS_BITS-1:0] SUM_POS    = POS_BITS'(FRAME_BYTES - 1);
   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] ANGLE_TYPE = 8'h53;

   // datapath widths
   localparam int HEADING_BITS = 32;
   localparam int AGE_BITS     = 16;
   localparam int YAW_BITS     = 16;
   localparam int TIMEOUT_BITS = 16;
   localparam int AGE_CMP_BITS = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;
   localparam int OUT_HEADING_BITS = 32;
   localparam int WIDE_HEADING_BITS = 64;

   // configuration register map
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERT_DIRECTION = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRESH_LIMIT      = CSR_INDEX_BITS'(1);
   localparam logic [TIMEOUT_BITS-1:0]   TIMEOUT_RESET        = TIMEOUT_BITS'(500);

   // input action codes
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic signed [OUT_HEADING_BITS-1:0] heading;
      logic                               has_baseline;
      logic                               is_fresh;
      logic                               heading_updated;
   } rsp_type;

   typedef struct packed {
      logic                    invert_direction;
      logic [TIMEOUT_BITS-1:0] fresh_limit;
   } cfg_type;

   // parser to tracker: a completed angle frame
   typedef struct packed {
      logic                valid;
      logic [YAW_BITS-1:0] yaw;
   } yaw_type;

endpackage

// ----- rtl/iafhu_frame_parser.sv -----
// ----------------------------------------------------------------------------
// iafhu_frame_parser
// Hunts for sync, collects frame bytes, checks the sum and flags angle frames.
// ----------------------------------------------------------------------------
module iafhu_frame_parser
   import iafhu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output yaw_type frame
);

   logic [POS_BITS-1:0] position_ff, position_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          type_ff, type_in;
   logic [7:0]          yaw_lo_ff, yaw_lo_in;
   logic [7:0]          yaw_hi_ff, yaw_hi_in;
   logic                take_byte;
   logic                sum_ok;

   assign take_byte = step && (item.action == ACTION_BYTE);
   assign sum_ok    = (sum_ff == item.rx_byte);

   // frame sequencing
   always_comb begin
      position_in = position_ff;
      sum_in      = sum_ff;
      type_in     = type_ff;
      yaw_lo_in   = yaw_lo_ff;
      yaw_hi_in   = yaw_hi_ff;
      frame.valid = 1'b0;
      frame.yaw   = {yaw_hi_ff, yaw_lo_ff};
      if (take_byte) begin
         if (position_ff == '0) begin
            // hunting for the sync byte
            if (item.rx_byte == SYNC_BYTE) begin
               sum_in      = item.rx_byte;
               position_in = POS_BITS'(1);
            end
         end else if (position_ff < SUM_POS) begin
            if (position_ff == TYPE_POS) begin
               type_in = item.rx_byte;
            end else if (position_ff == YAW_LO_POS) begin
               yaw_lo_in = item.rx_byte;
            end else if (position_ff == YAW_HI_POS) begin
               yaw_hi_in = item.rx_byte;
            end
            sum_in      = sum_ff + item.rx_byte;
            position_in = position_ff + POS_BITS'(1);
         end else if (sum_ok) begin
            frame.valid = (type_ff == ANGLE_TYPE);
            position_in = '0;
         end else if (item.rx_byte == SYNC_BYTE) begin
            // bad sum, but this byte may open the next frame
            sum_in      = item.rx_byte;
            position_in = POS_BITS'(1);
         end else begin
            position_in = '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         sum_ff      <= '0;
      end else begin
         position_ff <= position_in;
         sum_ff      <= sum_in;
      end
   end

   // frame field stores
   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      yaw_lo_ff <= yaw_lo_in;
      yaw_hi_ff <= yaw_hi_in;
   end

endmodule

// ----- rtl/iafhu_heading_tracker.sv -----
// ----------------------------------------------------------------------------
// iafhu_heading_tracker
// Unwraps yaw into a saturating heading and ages the last angle frame.
// ----------------------------------------------------------------------------
module iafhu_heading_tracker
   import iafhu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  yaw_type frame,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic signed [HEADING_BITS-1:0] HEADING_MAX = {1'b0, {(HEADING_BITS-1){1'b1}}};
   localparam logic signed [HEADING_BITS-1:0] HEADING_MIN = {1'b1, {(HEADING_BITS-1){1'b0}}};
   localparam logic [AGE_BITS-1:0]            AGE_MAX     = '1;

   logic                           baseline_ff, baseline_in;
   logic [YAW_BITS-1:0]            prev_yaw_ff, prev_yaw_in;
   logic signed [HEADING_BITS-1:0] heading_ff, heading_in;
   logic [AGE_BITS-1:0]            age_ff, age_in;
   logic [YAW_BITS-1:0]            yaw;
   logic [YAW_BITS-1:0]            delta;
   logic [HEADING_BITS:0]          sum;
   logic                           tick;
   logic                           take;
   logic signed [WIDE_HEADING_BITS-1:0] heading_wide;

   assign tick = step && (item.action == ACTION_TICK);
   assign take = step && frame.valid;

   // optional direction flip, wraps at the negative limit
   assign yaw   = cfg.invert_direction ? YAW_BITS'(-frame.yaw) : frame.yaw;
   assign delta = yaw - prev_yaw_ff;
   assign sum   = {heading_ff[HEADING_BITS-1], heading_ff}
                + {{(HEADING_BITS+1-YAW_BITS){delta[YAW_BITS-1]}}, delta};

   // heading and baseline update
   always_comb begin
      baseline_in = baseline_ff;
      prev_yaw_in = prev_yaw_ff;
      heading_in  = heading_ff;
      if (take) begin
         baseline_in = 1'b1;
         prev_yaw_in = yaw;
         if (!baseline_ff) begin
            heading_in = '0;
         end else if (sum[HEADING_BITS] != sum[HEADING_BITS-1]) begin
            heading_in = sum[HEADING_BITS] ? HEADING_MIN : HEADING_MAX;
         end else begin
            heading_in = sum[HEADING_BITS-1:0];
         end
      end
   end

   // frame age, saturating
   always_comb begin
      age_in = age_ff;
      if (take) begin
         age_in = '0;
      end else if (tick && (age_ff != AGE_MAX)) begin
         age_in = age_ff + AGE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= 1'b0;
         prev_yaw_ff <= '0;
         heading_ff  <= '0;
         age_ff      <= '0;
      end else begin
         baseline_ff <= baseline_in;
         prev_yaw_ff <= prev_yaw_in;
         heading_ff  <= heading_in;
         age_ff      <= age_in;
      end
   end

   // result reflects the state after this item
   assign heading_wide           = WIDE_HEADING_BITS'(heading_in);
   assign result.heading         = heading_wide[OUT_HEADING_BITS-1:0];
   assign result.has_baseline    = baseline_in;
   assign result.is_fresh        = baseline_in &&
      (AGE_CMP_BITS'(age_in) <= AGE_CMP_BITS'(cfg.fresh_limit));
   assign result.heading_updated = take;

endmodule

// ----- rtl/imu_angle_frame_heading_unwrap_core.sv -----
// ----------------------------------------------------------------------------
// imu_angle_frame_heading_unwrap_core
// Serial IMU angle frame parser with continuous heading output.
// ----------------------------------------------------------------------------
// Each req_ transfer carries one received byte (action 0) or one
// millisecond tick (action 1); each produces exactly one rsp_ transfer
// with the heading, baseline and freshness flags after that item.
// Items pass an input register, then the parser and heading update
// logic, then a result register, which drives rsp_valid and rsp_data.
// One item is taken per cycle while rsp_ready stays high.
// When the receiver stalls, the result register holds its item and the
// input register takes one more; req_ready then drops until the result
// register drains. No item is lost or repeated.
// Configuration: csr_ index 0 sets invert_direction, index 1 sets the
// freshness limit (largest age still fresh), other indexes are ignored;
// csr_ready is always high. Write configuration only while no item is
// in flight.
// Reset (synchronous) empties both registers, clears the frame hunt,
// the baseline, the heading and the age, and restores the limit to 500.
// ----------------------------------------------------------------------------
module imu_angle_frame_heading_unwrap_core
   import iafhu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   cfg_type cfg_ff, cfg_in;
   logic    advance;
   logic    req_take;
   yaw_type frame;
   rsp_type result;

   // pipeline handshake
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INVERT_DIRECTION: cfg_in.invert_direction = csr_data[0];
            CSR_FRESH_LIMIT:      cfg_in.fresh_limit = csr_data[TIMEOUT_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_direction <= 1'b0;
         cfg_ff.fresh_limit      <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iafhu_frame_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_data_ff),
      .frame (frame)
   );

   iafhu_heading_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .frame  (frame),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- rtl/iafhu_checker.sv -----
// ----------------------------------------------------------------------------
// iafhu_checker
// Port-level checks of the heading unwrap core, bound to the top level.
// ----------------------------------------------------------------------------
module iafhu_checker
   import iafhu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // an update always leaves a baseline behind
   a_update_baseline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.heading_updated |-> rsp_data.has_baseline)
      else $error("heading update without baseline");

   // freshness needs a baseline
   a_fresh_baseline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_fresh |-> rsp_data.has_baseline)
      else $error("fresh without baseline");

   // heading stays zero until the first angle frame
   a_zero_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_baseline |-> rsp_data.heading == '0)
      else $error("heading moved before baseline");

endmodule

bind imu_angle_frame_heading_unwrap_core iafhu_checker u_iafhu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
